### hw/rtl/i2cmts_pkg.sv
// Package with the types, codes and helpers of the I2C master transfer sequencer.
package i2cmts_pkg;

  localparam int WRITE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(WRITE_DEPTH);
  localparam int WCNT_W      = 5;
  localparam int RCNT_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int PHASE_W     = 3;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 48;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_EVENT = 2'd2,
    CMD_CLEAR = 2'd3
  } command_t;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b000_0001,
    PH_START    = 7'b000_0010,
    PH_REPSTART = 7'b000_0100,
    PH_ADDRESS  = 7'b000_1000,
    PH_SEND     = 7'b001_0000,
    PH_RECEIVE  = 7'b010_0000,
    PH_ERROR    = 7'b100_0000
  } phase_t;

  localparam logic [PHASE_W-1:0] CODE_IDLE     = 3'd0;
  localparam logic [PHASE_W-1:0] CODE_START    = 3'd1;
  localparam logic [PHASE_W-1:0] CODE_REPSTART = 3'd2;
  localparam logic [PHASE_W-1:0] CODE_ADDRESS  = 3'd3;
  localparam logic [PHASE_W-1:0] CODE_SEND     = 3'd4;
  localparam logic [PHASE_W-1:0] CODE_RECEIVE  = 3'd5;
  localparam logic [PHASE_W-1:0] CODE_ERROR    = 3'd6;

  function automatic logic [PHASE_W-1:0] phase_code(phase_t ph);
    logic [PHASE_W-1:0] code;
    unique case (ph)
      PH_IDLE:     code = CODE_IDLE;
      PH_START:    code = CODE_START;
      PH_REPSTART: code = CODE_REPSTART;
      PH_ADDRESS:  code = CODE_ADDRESS;
      PH_SEND:     code = CODE_SEND;
      PH_RECEIVE:  code = CODE_RECEIVE;
      PH_ERROR:    code = CODE_ERROR;
      default:     code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: input register, phase logic, result register.
//
//  Channel | Signals                      | Carries
//  --------+------------------------------+------------------------------------------
//  s       | s_tvalid s_tready s_tdata    | commands and peripheral event flags
//          | s_tuser                      | command kind
//  m       | m_tvalid m_tready m_tdata    | one result per command
//
// Each transfer passes the input register and then the result register, whose
// output is offered on the m side; one transfer is taken per cycle while the m side
// does not stall, bounded by the combinational phase decision that reads and updates
// the sequencer state.
// Reset clears the phase, the counters and both valid flags; the write buffer is
// not cleared. A stall on the m side holds the result and, once the input register
// is also full, drops s_tready.
module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0: device_address[7:0], write_count[12:8], read_count[28:13],
  // buffer_slot[32:29], data_byte[40:33], start_sent[41], address_done[42],
  // transmit_empty[43], transfer_finished[44], receive_full[45], bus_fault[46].
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // Fields from bit 0: command[1:0].
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0: issue_start[0], issue_stop[1], send_valid[2], send_value[10:3],
  // ack_valid[11], ack_level[12], recv_valid[13], recv_value[21:14],
  // recv_position[37:22], finished[38], phase_now[41:39], failed[42].
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic                 in_valid;
  logic [IN_DATA_W-1:0] in_data;
  logic [1:0]           in_user;
  logic                 advance;

  phase_t              phase, phase_next, work_phase;
  logic [BYTE_W-1:0]   target_address, target_address_next;
  logic [WCNT_W-1:0]   writes_left, writes_left_next;
  logic [SLOT_W-1:0]   write_position, write_position_next;
  logic [RCNT_W-1:0]   reads_left, reads_left_next;
  logic [RCNT_W-1:0]   read_position, read_position_next;
  logic [BYTE_W-1:0]   write_buffer [WRITE_DEPTH];

  command_t            cmd;
  logic [BYTE_W-1:0]   dev;
  logic [WCNT_W-1:0]   wcnt;
  logic [RCNT_W-1:0]   rcnt;
  logic [SLOT_W-1:0]   slot;
  logic [BYTE_W-1:0]   dbyte;
  logic                sb, addr_ok, txe, btf, rxne, fault;
  logic                buf_we;

  logic                r_start, r_stop, r_send_valid, r_ack_valid, r_ack_level;
  logic                r_recv_valid, r_finished;
  logic [BYTE_W-1:0]   r_send_value, r_recv_value;
  logic [RCNT_W-1:0]   r_recv_position;
  logic [PHASE_W-1:0]  r_phase;
  logic                r_failed;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_user <= s_tuser;
    end
  end

  assign cmd     = command_t'(in_user);
  assign dev     = in_data[7:0];
  assign wcnt    = in_data[12:8];
  assign rcnt    = in_data[28:13];
  assign slot    = in_data[32:29];
  assign dbyte   = in_data[40:33];
  assign sb      = in_data[41];
  assign addr_ok = in_data[42];
  assign txe     = in_data[43];
  assign btf     = in_data[44];
  assign rxne    = in_data[45];
  assign fault   = in_data[46];

  always_comb begin
    work_phase          = phase;
    target_address_next = target_address;
    writes_left_next    = writes_left;
    write_position_next = write_position;
    reads_left_next     = reads_left;
    read_position_next  = read_position;
    buf_we              = 1'b0;
    r_start             = 1'b0;
    r_stop              = 1'b0;
    r_send_valid        = 1'b0;
    r_send_value        = '0;
    r_ack_valid         = 1'b0;
    r_ack_level         = 1'b0;
    r_recv_valid        = 1'b0;
    r_recv_value        = '0;
    r_recv_position     = '0;
    r_finished          = 1'b0;

    unique case (cmd)
      CMD_LOAD: begin
        buf_we = 1'b1;
      end
      CMD_START: begin
        if (phase == PH_IDLE) begin
          target_address_next = dev;
          writes_left_next    = (wcnt > WCNT_W'(WRITE_DEPTH)) ? WCNT_W'(WRITE_DEPTH) : wcnt;
          write_position_next = '0;
          reads_left_next     = rcnt;
          read_position_next  = '0;
          work_phase          = PH_START;
          r_start             = 1'b1;
        end
      end
      CMD_EVENT: begin
        if (phase != PH_IDLE) begin
          if (fault) begin
            r_stop     = 1'b1;
            work_phase = PH_ERROR;
          end else begin
            unique case (phase)
              PH_START: begin
                if (sb) begin
                  r_send_valid = 1'b1;
                  r_send_value = {target_address[7:1], 1'b0};
                  work_phase   = PH_ADDRESS;
                end
              end
              PH_REPSTART: begin
                if (sb) begin
                  r_send_valid = 1'b1;
                  r_send_value = {target_address[7:1], 1'b1};
                  work_phase   = PH_ADDRESS;
                end
              end
              PH_ADDRESS: begin
                if (addr_ok) begin
                  if (writes_left != '0) begin
                    work_phase = PH_SEND;
                  end else if (reads_left != '0) begin
                    r_ack_valid = 1'b1;
                    if (reads_left == RCNT_W'(1)) begin
                      r_stop = 1'b1;
                    end else begin
                      r_ack_level = 1'b1;
                    end
                    work_phase = PH_RECEIVE;
                  end else begin
                    r_stop     = 1'b1;
                    r_finished = 1'b1;
                    work_phase = PH_IDLE;
                  end
                end
              end
              PH_SEND: begin
                if (txe) begin
                  if (writes_left != '0) begin
                    writes_left_next    = writes_left - WCNT_W'(1);
                    r_send_valid        = 1'b1;
                    r_send_value        = write_buffer[write_position];
                    write_position_next = write_position + SLOT_W'(1);
                  end else if (reads_left != '0) begin
                    r_start    = 1'b1;
                    work_phase = PH_REPSTART;
                  end else if (btf) begin
                    r_stop     = 1'b1;
                    r_finished = 1'b1;
                    work_phase = PH_IDLE;
                  end
                end
              end
              PH_RECEIVE: begin
                if (rxne) begin
                  r_recv_valid       = 1'b1;
                  r_recv_value       = dbyte;
                  r_recv_position    = read_position;
                  read_position_next = read_position + RCNT_W'(1);
                  if (reads_left > RCNT_W'(2)) begin
                    reads_left_next = reads_left - RCNT_W'(1);
                  end else if (reads_left == RCNT_W'(2)) begin
                    reads_left_next = reads_left - RCNT_W'(1);
                    r_ack_valid     = 1'b1;
                    r_stop          = 1'b1;
                  end else begin
                    reads_left_next = '0;
                    r_finished      = 1'b1;
                    work_phase      = PH_IDLE;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      CMD_CLEAR: begin
      end
      default: begin
      end
    endcase

    r_phase    = phase_code(work_phase);
    r_failed   = (work_phase == PH_ERROR);
    phase_next = (cmd == CMD_CLEAR) ? PH_IDLE : work_phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      target_address <= '0;
      writes_left    <= '0;
      write_position <= '0;
      reads_left     <= '0;
      read_position  <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      target_address <= target_address_next;
      writes_left    <= writes_left_next;
      write_position <= write_position_next;
      reads_left     <= reads_left_next;
      read_position  <= read_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && buf_we) begin
      write_buffer[slot] <= dbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= {5'b0, r_failed, r_phase, r_finished, r_recv_position, r_recv_value,
                  r_recv_valid, r_ack_level, r_ack_valid, r_send_value, r_send_valid,
                  r_stop, r_start};
    end
  end

`ifndef NO_ASSERTIONS
  a_failed_is_error: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[42] == (m_tdata[41:39] == CODE_ERROR)))
    else $error("Failed flag disagrees with the reported phase.");

  a_no_start_and_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("Start and stop issued in the same result.");

  a_recv_in_receive: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[13]) |->
      (m_tdata[41:39] == CODE_RECEIVE || m_tdata[41:39] == CODE_IDLE))
    else $error("Received byte delivered outside the receive phase.");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |=> (in_valid && $stable(in_data)))
    else $error("Input register lost a transfer while the output stalled.");
`endif

endmodule
